FILE: rtl/gga_pkg.sv
// Shared types, codes and arithmetic helpers for the grid gradient block.
// No dependencies; imported by every other file of the block.
package gga_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DATA_W       = 32;
    localparam int SIZE_W       = 7;
    localparam int IDX_W        = 6;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_WIDTH_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_WIDTH_Y = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
        logic signed [DATA_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] grad_x;
        logic signed [DATA_W-1:0] grad_y;
        logic                     clipped;
    } t_result;

    typedef struct packed {
        logic [SIZE_W-1:0] used_w;
        logic [SIZE_W-1:0] used_h;
        logic              wrap_x;
        logic              wrap_y;
        logic [DATA_W-1:0] recip_x;
        logic [DATA_W-1:0] recip_y;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             central;
    } t_nbr;

    typedef enum logic [2:0] {
        ADDR_ITEM,
        ADDR_XM,
        ADDR_XP,
        ADDR_YM,
        ADDR_YP
    } t_addr_sel;

    typedef struct packed {
        logic      load_item;
        logic      mem_we;
        t_addr_sel addr_sel;
        logic      cap_first;
        logic      cap_diff;
        logic      do_mul;
        logic      sel_y;
        logic      fin_x;
        logic      fin_y;
        logic      res_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic item_read;
    } t_dp_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHORT,
        ST_RD_XM,
        ST_RD_XP,
        ST_RD_YM,
        ST_RD_YP,
        ST_FIN_X,
        ST_MUL_Y,
        ST_FIN_Y
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clip;
    } t_sat;

    // Round half away from zero, shift by 16 or 17, saturate to 32 bits.
    function automatic t_sat round_sat(input logic [63:0] prod, input logic neg,
                                       input logic central);
        logic [63:0] sum;
        logic [47:0] q;
        t_sat        res;
        sum = prod + (central ? 64'h0000_0000_0001_0000 : 64'h0000_0000_0000_8000);
        q   = central ? {1'b0, sum[63:17]} : sum[63:16];
        res.clip = 1'b0;
        if (neg) begin
            if (q > 48'h0000_8000_0000) begin
                res.clip  = 1'b1;
                res.value = 32'h8000_0000;
            end else begin
                res.value = 32'd0 - q[31:0];
            end
        end else begin
            if (q > 48'h0000_7FFF_FFFF) begin
                res.clip  = 1'b1;
                res.value = 32'h7FFF_FFFF;
            end else begin
                res.value = q[31:0];
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/grid_gradient_boundary_aware_top.sv
// Top level of the grid gradient block: configuration, sequencer, datapath.
// Depends on gga_pkg, gga_cfg, gga_ctrl and gga_dp.
//
// Usage: raise start with an item while busy is low. A read item keeps busy high
// through four back-to-back reads of the single-port sample store followed by two
// passes through one shared 32x32 multiplier with round and saturate; a write item,
// or an item addressed outside the grid in use, takes a short path without reads.
// Each item yields one result word on o_result, marked by o_valid for a single
// cycle; the receiver cannot stall it, so capture it when o_valid is high. Write
// configuration only while busy is low and no result is pending. Cells are
// undefined until written.
module grid_gradient_boundary_aware_top import gga_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 start,
    input  t_item                i_item,
    output logic                 busy,
    output logic                 o_valid,
    output t_result              o_result
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    gga_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gga_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_valid)
    );

    gga_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_item   (i_item),
        .i_cfg    (cfg),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result)
    );

endmodule

FILE: rtl/gga_cfg.sv
// Configuration registers and clamped grid size for the grid gradient block.
// Depends on gga_pkg.
module gga_cfg import gga_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    localparam int HI_W = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam int HI_H = (MAX_ROWS < 64) ? MAX_ROWS : 64;

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic              r_wrap_x;
    logic              r_wrap_y;
    logic [DATA_W-1:0] r_recip_x;
    logic [DATA_W-1:0] r_recip_y;

    function automatic logic [SIZE_W-1:0] used_size(input logic [SIZE_W-1:0] val,
                                                    input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        if (val < SIZE_W'(2)) begin
            res = SIZE_W'(2);
        end else if (val > hi) begin
            res = hi;
        end else begin
            res = val;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= SIZE_W'(64);
            r_height  <= SIZE_W'(64);
            r_wrap_x  <= 1'b1;
            r_wrap_y  <= 1'b1;
            r_recip_x <= 32'h0001_0000;
            r_recip_y <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:    r_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_HEIGHT:   r_height  <= i_cfg_data[SIZE_W-1:0];
                CFG_WRAP_X:        r_wrap_x  <= i_cfg_data[0];
                CFG_WRAP_Y:        r_wrap_y  <= i_cfg_data[0];
                CFG_RECIP_WIDTH_X: r_recip_x <= i_cfg_data;
                CFG_RECIP_WIDTH_Y: r_recip_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.used_w  = used_size(r_width, SIZE_W'(HI_W));
        o_cfg.used_h  = used_size(r_height, SIZE_W'(HI_H));
        o_cfg.wrap_x  = r_wrap_x;
        o_cfg.wrap_y  = r_wrap_y;
        o_cfg.recip_x = r_recip_x;
        o_cfg.recip_y = r_recip_y;
    end

endmodule

FILE: rtl/gga_ctrl.sv
// Sequencer for the grid gradient block: steps the four store reads and
// the shared multiplier. Depends on gga_pkg.
module gga_ctrl import gga_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_status.item_read ? ST_RD_XM : ST_SHORT;
                end
            end
            ST_SHORT: n_state = ST_IDLE;
            ST_RD_XM: n_state = ST_RD_XP;
            ST_RD_XP: n_state = ST_RD_YM;
            ST_RD_YM: n_state = ST_RD_YP;
            ST_RD_YP: n_state = ST_FIN_X;
            ST_FIN_X: n_state = ST_MUL_Y;
            ST_MUL_Y: n_state = ST_FIN_Y;
            ST_FIN_Y: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_ITEM;
        n_done         = 1'b0;
        case (r_state)
            ST_IDLE: o_cmd.load_item = i_start;
            ST_SHORT: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.res_zero = 1'b1;
                n_done         = 1'b1;
            end
            ST_RD_XM: o_cmd.addr_sel = ADDR_XM;
            ST_RD_XP: begin
                o_cmd.addr_sel  = ADDR_XP;
                o_cmd.cap_first = 1'b1;
            end
            ST_RD_YM: begin
                o_cmd.addr_sel = ADDR_YM;
                o_cmd.cap_diff = 1'b1;
            end
            ST_RD_YP: begin
                o_cmd.addr_sel  = ADDR_YP;
                o_cmd.cap_first = 1'b1;
                o_cmd.do_mul    = 1'b1;
            end
            ST_FIN_X: begin
                o_cmd.cap_diff = 1'b1;
                o_cmd.fin_x    = 1'b1;
            end
            ST_MUL_Y: begin
                o_cmd.do_mul = 1'b1;
                o_cmd.sel_y  = 1'b1;
            end
            ST_FIN_Y: begin
                o_cmd.fin_y = 1'b1;
                n_done      = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

FILE: rtl/gga_dp.sv
// Datapath for the grid gradient block: sample store, neighbor indexes,
// difference, shared 32x32 multiplier, rounding and saturation. Depends on gga_pkg.
module gga_dp import gga_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic       i_clk,
    input  t_item      i_item,
    input  t_cfg       i_cfg,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_result    o_result
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    function automatic t_nbr neighbors(input logic [IDX_W-1:0] idx,
                                       input logic [SIZE_W-1:0] size,
                                       input logic wrap);
        logic [SIZE_W-1:0] idx7;
        logic [SIZE_W-1:0] lo7;
        logic [SIZE_W-1:0] hi7;
        t_nbr              res;
        idx7        = {1'b0, idx};
        res.central = 1'b1;
        if (wrap) begin
            lo7 = (idx7 == '0) ? size - SIZE_W'(1) : idx7 - SIZE_W'(1);
            hi7 = (idx7 + SIZE_W'(1) == size) ? '0 : idx7 + SIZE_W'(1);
        end else if (idx7 == '0) begin
            lo7         = '0;
            hi7         = SIZE_W'(1);
            res.central = 1'b0;
        end else if (idx7 == size - SIZE_W'(1)) begin
            lo7         = idx7 - SIZE_W'(1);
            hi7         = idx7;
            res.central = 1'b0;
        end else begin
            lo7 = idx7 - SIZE_W'(1);
            hi7 = idx7 + SIZE_W'(1);
        end
        res.lo = lo7[IDX_W-1:0];
        res.hi = hi7[IDX_W-1:0];
        return res;
    endfunction

    logic [DATA_W-1:0] r_store [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic              r_op;
    logic              r_inrange;
    logic [IDX_W-1:0]  r_col;
    logic [IDX_W-1:0]  r_row;
    logic [DATA_W-1:0] r_sample;
    t_nbr              r_nx;
    t_nbr              r_ny;

    logic [DATA_W-1:0] r_pm;
    logic [DATA_W:0]   r_diff;
    logic [63:0]       r_prod;
    logic              r_neg;
    logic              r_central;
    logic [DATA_W-1:0] r_gx;
    logic              r_clip_x;
    t_result           r_res;

    logic              in_range;
    t_nbr              nx;
    t_nbr              ny;
    logic [IDX_W-1:0]  a_col;
    logic [IDX_W-1:0]  a_row;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W:0]   mag33;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] recip;
    t_sat              sat;

    always_comb begin
        in_range = ({1'b0, i_item.col} < i_cfg.used_w) && ({1'b0, i_item.row} < i_cfg.used_h);
        nx       = neighbors(i_item.col, i_cfg.used_w, i_cfg.wrap_x);
        ny       = neighbors(i_item.row, i_cfg.used_h, i_cfg.wrap_y);
        o_status.item_read = (i_item.operation == OP_READ) && in_range;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op      <= i_item.operation;
            r_inrange <= in_range;
            r_col     <= i_item.col;
            r_row     <= i_item.row;
            r_sample  <= i_item.sample;
            r_nx      <= nx;
            r_ny      <= ny;
        end
    end

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_ITEM: begin a_col = r_col;   a_row = r_row;   end
            ADDR_XM:   begin a_col = r_nx.lo; a_row = r_row;   end
            ADDR_XP:   begin a_col = r_nx.hi; a_row = r_row;   end
            ADDR_YM:   begin a_col = r_col;   a_row = r_ny.lo; end
            ADDR_YP:   begin a_col = r_col;   a_row = r_ny.hi; end
            default:   begin a_col = r_col;   a_row = r_row;   end
        endcase
        mem_addr = AW'(32'(a_row) * MAX_COLS + 32'(a_col));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we && r_op == OP_WRITE && r_inrange) begin
            r_store[mem_addr] <= r_sample;
        end
        r_rdata <= r_store[mem_addr];
    end

    always_comb begin
        mag33 = r_diff[DATA_W] ? (DATA_W+1)'(0) - r_diff : r_diff;
        mag   = mag33[DATA_W-1:0];
        recip = i_cmd.sel_y ? i_cfg.recip_y : i_cfg.recip_x;
        sat   = round_sat(r_prod, r_neg, r_central);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_first) begin
            r_pm <= r_rdata;
        end
        if (i_cmd.cap_diff) begin
            r_diff <= {r_rdata[DATA_W-1], r_rdata} - {r_pm[DATA_W-1], r_pm};
        end
        if (i_cmd.do_mul) begin
            r_prod    <= {32'd0, mag} * {32'd0, recip};
            r_neg     <= r_diff[DATA_W];
            r_central <= i_cmd.sel_y ? r_ny.central : r_nx.central;
        end
        if (i_cmd.fin_x) begin
            r_gx     <= sat.value;
            r_clip_x <= sat.clip;
        end
        if (i_cmd.fin_y) begin
            r_res.grad_x  <= r_gx;
            r_res.grad_y  <= sat.value;
            r_res.clipped <= r_clip_x | sat.clip;
        end else if (i_cmd.res_zero) begin
            r_res <= '0;
        end
    end

    assign o_result = r_res;

endmodule

FILE: sim/grid_gradient_boundary_aware_top_tb.sv
// Self-checking testbench for grid_gradient_boundary_aware_top: sample writes and
// gradient reads over several grid settings, checked against an in-bench predictor.
// Depends on gga_pkg and the block's RTL only.
module grid_gradient_boundary_aware_top_tb import gga_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_COLS   = DEF_MAX_COLS;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             central;
    } t_axis_pick;

    typedef struct packed {
        t_item word;
        logic  hold;
    } t_stim;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;
    logic                 start = 1'b0;
    t_item                i_item = '0;
    logic                 busy;
    logic                 o_valid;
    t_result              o_result;

    logic [SIZE_W-1:0] cfg_cols = 7'd64;
    logic [SIZE_W-1:0] cfg_rows = 7'd64;
    logic              cfg_wrap_x = 1'b1;
    logic              cfg_wrap_y = 1'b1;
    logic [DATA_W-1:0] cfg_recip_x = 32'h0001_0000;
    logic [DATA_W-1:0] cfg_recip_y = 32'h0001_0000;

    logic signed [DATA_W-1:0] pressure_mirror [0:GRID_COLS*DEF_MAX_ROWS-1];
    bit                       cell_filled [0:GRID_COLS*DEF_MAX_ROWS-1];

    t_stim   stim_q[$];
    t_result grad_expected[$];
    t_result grad_pred = '0;
    logic    pred_pending = 1'b0;

    int items_sent = 0;
    int results_seen = 0;
    int clips_seen = 0;
    int errors = 0;
    int gap_left = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int stim_total = 0;
    int reads_queued = 0;
    int settings_used = 1;

    grid_gradient_boundary_aware_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned span_of(logic [SIZE_W-1:0] v);
        if (v < 2) return 2;
        if (v > 64) return 64;
        return 32'(v);
    endfunction

    function automatic t_axis_pick pick_axis(int unsigned idx, int unsigned span, bit periodic);
        t_axis_pick p;
        if (periodic) begin
            p.lo      = IDX_W'((idx == 0) ? span - 1 : idx - 1);
            p.hi      = IDX_W'((idx + 1 == span) ? 0 : idx + 1);
            p.central = 1'b1;
        end else if (idx == 0) begin
            p.lo      = '0;
            p.hi      = IDX_W'(1);
            p.central = 1'b0;
        end else if (idx == span - 1) begin
            p.lo      = IDX_W'(idx - 1);
            p.hi      = IDX_W'(idx);
            p.central = 1'b0;
        end else begin
            p.lo      = IDX_W'(idx - 1);
            p.hi      = IDX_W'(idx + 1);
            p.central = 1'b1;
        end
        return p;
    endfunction

    function automatic logic [DATA_W-1:0] scaled_slope(logic signed [DATA_W-1:0] upper,
                                                       logic signed [DATA_W-1:0] lower,
                                                       logic [DATA_W-1:0] recip,
                                                       bit central, output bit clip);
        longint          d;
        longint unsigned mag;
        longint unsigned rc;
        longint unsigned q;
        d    = longint'(upper) - longint'(lower);
        mag  = (d < 0) ? -d : d;
        rc   = 64'(recip);
        q    = (mag * rc + (central ? 64'd65536 : 64'd32768)) >> (central ? 17 : 16);
        clip = 1'b0;
        if (d < 0) begin
            if (q > 64'h8000_0000) begin
                clip = 1'b1;
                return 32'h8000_0000;
            end
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7FFF_FFFF) begin
            clip = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic t_result gradient_of(t_item word);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        t_axis_pick  px;
        t_axis_pick  py;
        t_result     res;
        bit          clip_x;
        bit          clip_y;
        w   = span_of(cfg_cols);
        h   = span_of(cfg_rows);
        c   = 32'(word.col);
        r   = 32'(word.row);
        res = '0;
        if (c >= w || r >= h) return res;
        if (word.operation == OP_WRITE) begin
            pressure_mirror[r*GRID_COLS+c] = word.sample;
            return res;
        end
        px = pick_axis(c, w, cfg_wrap_x);
        py = pick_axis(r, h, cfg_wrap_y);
        res.grad_x = scaled_slope(pressure_mirror[r*GRID_COLS+px.hi],
                                  pressure_mirror[r*GRID_COLS+px.lo],
                                  cfg_recip_x, px.central, clip_x);
        res.grad_y = scaled_slope(pressure_mirror[py.hi*GRID_COLS+c],
                                  pressure_mirror[py.lo*GRID_COLS+c],
                                  cfg_recip_y, py.central, clip_y);
        res.clipped = clip_x | clip_y;
        return res;
    endfunction

    function automatic int pause_len();
        int unsigned roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            5, 6:    return $urandom_range(0, 2047) - 1024;
            7:       return 32'h7FFF_FFFF;
            8:       return 32'h8000_0000;
            9:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_recip();
        case ($urandom_range(0, 9))
            0:          return 32'h0;
            1:          return 32'hFFFF_FFFF;
            2:          return 32'h0001_0000;
            3, 4, 5:    return $urandom;
            default:    return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return SIZE_W'($urandom_range(0, 1));
            1:       return 7'd2;
            2:       return 7'd3;
            3:       return 7'd64;
            4:       return SIZE_W'($urandom_range(65, 127));
            5:       return SIZE_W'($urandom_range(13, 63));
            default: return SIZE_W'($urandom_range(4, 12));
        endcase
    endfunction

    function automatic void queue_item(logic op, int unsigned c, int unsigned r,
                                       logic [DATA_W-1:0] sample);
        t_stim s;
        s.word.operation = op;
        s.word.col       = IDX_W'(c);
        s.word.row       = IDX_W'(r);
        s.word.sample    = sample;
        s.hold           = ($urandom_range(0, 99) == 0);
        if (op == OP_WRITE && c < span_of(cfg_cols) && r < span_of(cfg_rows))
            cell_filled[r*GRID_COLS+c] = 1'b1;
        if (op == OP_READ) reads_queued++;
        stim_q = {stim_q, s};
        stim_total++;
    endfunction

    // Stage a read of an in-grid cell, writing first whatever it and its neighbours lack.
    function automatic void queue_read(int unsigned c, int unsigned r);
        t_axis_pick  px;
        t_axis_pick  py;
        int unsigned need_c [5];
        int unsigned need_r [5];
        px = pick_axis(c, span_of(cfg_cols), cfg_wrap_x);
        py = pick_axis(r, span_of(cfg_rows), cfg_wrap_y);
        need_c = '{c, 32'(px.lo), 32'(px.hi), c, c};
        need_r = '{r, r, r, 32'(py.lo), 32'(py.hi)};
        for (int k = 0; k < 5; k++) begin
            if (!cell_filled[need_r[k]*GRID_COLS+need_c[k]])
                queue_item(OP_WRITE, need_c[k], need_r[k], rand_sample());
        end
        queue_item(OP_READ, c, r, $urandom);
    endfunction

    task automatic fill_phase(int target);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned roll;
        logic        op;
        w = span_of(cfg_cols);
        h = span_of(cfg_rows);
        while (stim_total < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                c = $urandom_range(0, 63);
                r = $urandom_range(0, 63);
                if (w < 64 && (h == 64 || $urandom_range(0, 1)))
                    c = $urandom_range(w, 63);
                else if (h < 64)
                    r = $urandom_range(h, 63);
                op = 1'($urandom_range(0, 1));
                if (op == OP_READ && c < w && r < h)
                    queue_read(c, r);
                else
                    queue_item(op, c, r, $urandom);
            end else if (roll < 72) begin
                queue_read($urandom_range(0, w - 1), $urandom_range(0, h - 1));
            end else begin
                queue_item(OP_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                           rand_sample());
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (stim_q.size() != 0 || start || busy || items_sent != results_seen);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] data;
        data = value;
        case (index)
            CFG_GRID_WIDTH: begin
                data[DATA_W-1:SIZE_W] = (DATA_W-SIZE_W)'($urandom);
                cfg_cols = value[SIZE_W-1:0];
            end
            CFG_GRID_HEIGHT: begin
                data[DATA_W-1:SIZE_W] = (DATA_W-SIZE_W)'($urandom);
                cfg_rows = value[SIZE_W-1:0];
            end
            CFG_WRAP_X: begin
                data[DATA_W-1:1] = (DATA_W-1)'($urandom);
                cfg_wrap_x = value[0];
            end
            CFG_WRAP_Y: begin
                data[DATA_W-1:1] = (DATA_W-1)'($urandom);
                cfg_wrap_y = value[0];
            end
            CFG_RECIP_WIDTH_X: cfg_recip_x = value;
            default:           cfg_recip_y = value;
        endcase
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
    endtask

    task automatic configure(logic [SIZE_W-1:0] cols, logic [SIZE_W-1:0] rows,
                             logic wx, logic wy, logic [DATA_W-1:0] rx,
                             logic [DATA_W-1:0] ry);
        wait_drained();
        write_reg(CFG_GRID_WIDTH, DATA_W'(cols));
        write_reg(CFG_GRID_HEIGHT, DATA_W'(rows));
        write_reg(CFG_WRAP_X, DATA_W'(wx));
        write_reg(CFG_WRAP_Y, DATA_W'(wy));
        write_reg(CFG_RECIP_WIDTH_X, rx);
        write_reg(CFG_RECIP_WIDTH_Y, ry);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        bit    fire;
        bit    go;
        t_stim nxt;
        fire = start && !busy;
        go   = 1'b0;
        if (!i_rst_n) begin
            start        <= 1'b0;
            pred_pending <= 1'b0;
        end else begin
            if (fire) begin
                grad_pred  <= gradient_of(i_item);
                items_sent <= items_sent + 1;
            end
            pred_pending <= fire;
            if (!start || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() != 0 &&
                             (!stim_q[0].hold || items_sent + fire == results_seen)) begin
                    nxt      = stim_q.pop_front();
                    i_item   <= nxt.word;
                    go       = 1'b1;
                    gap_left = pause_len();
                end
                start <= go;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (pred_pending) grad_expected = {grad_expected, grad_pred};
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (o_result.clipped) clips_seen++;
            if (grad_expected.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_result);
                errors++;
            end else begin
                want = grad_expected.pop_front();
                if (o_result.grad_x !== want.grad_x) begin
                    $display("%0t: grad_x expected %h actual %h", $time, want.grad_x,
                             o_result.grad_x);
                    errors++;
                end
                if (o_result.grad_y !== want.grad_y) begin
                    $display("%0t: grad_y expected %h actual %h", $time, want.grad_y,
                             o_result.grad_y);
                    errors++;
                end
                if (o_result.clipped !== want.clipped) begin
                    $display("%0t: clipped expected %b actual %b", $time, want.clipped,
                             o_result.clipped);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_item(OP_WRITE, 0, 0, 32'h0001_0000);
        queue_item(OP_WRITE, 1, 0, 32'h7FFF_FFFF);
        queue_item(OP_WRITE, 63, 0, 32'h8000_0000);
        queue_item(OP_WRITE, 0, 1, 32'hFFFF_0000);
        queue_item(OP_WRITE, 0, 63, 32'h1234_5678);
        queue_item(OP_READ, 0, 0, 32'hFFFF_FFFF);

        configure(7'd1, 7'd3, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(OP_WRITE, 0, 0, 32'h7FFF_FFFF);
        queue_item(OP_WRITE, 1, 0, 32'h8000_0000);
        queue_item(OP_WRITE, 0, 1, 32'h0);
        queue_item(OP_WRITE, 1, 1, 32'hFFFF_FFFF);
        queue_item(OP_WRITE, 0, 2, 32'h8000_0000);
        queue_item(OP_WRITE, 1, 2, 32'h7FFF_FFFF);
        queue_item(OP_READ, 0, 0, 32'h0);
        queue_item(OP_READ, 1, 1, 32'h0);
        queue_item(OP_READ, 0, 2, 32'h0);
        queue_item(OP_READ, 1, 2, 32'h0);
        queue_item(OP_WRITE, 5, 1, 32'h5555_AAAA);
        queue_item(OP_READ, 1, 40, 32'h0);
        queue_item(OP_READ, 63, 63, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 14; phase++) begin
            if (phase == 0)
                configure(7'd127, 7'd64, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), rand_recip(), rand_recip());
            else
                configure(rand_size(), rand_size(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), rand_recip(), rand_recip());
            fill_phase(19 + (phase + 1) * 138);
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("%0d words sent (%0d gradient reads) under %0d register settings",
                 items_sent, reads_queued, settings_used);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 results_seen, clips_seen, errors);
        if (errors == 0 && grad_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
